@@ hdl/iirdf1_pkg.sv @@
package iirdf1_pkg;

	// field and register widths
	localparam int CHAN_W   = 2;
	localparam int SAMPLE_W = 16;
	localparam int COEF_W   = 18;
	localparam int Y_W      = 24;
	localparam int CFG_A_W  = 3;

	// coefficient reset values, Q4.14
	localparam logic signed [COEF_W-1:0] COEF_ZERO = '0;
	localparam logic signed [COEF_W-1:0] COEF_ONE  = COEF_W'(16384);

	// configuration register indexes
	typedef enum logic [CFG_A_W-1:0] {
		REG_B0 = 3'd0,
		REG_B1 = 3'd1,
		REG_B2 = 3'd2,
		REG_A1 = 3'd3,
		REG_A2 = 3'd4
	} reg_idx_t;

	// coefficient set
	typedef struct packed {
		logic signed [COEF_W-1:0] b0;
		logic signed [COEF_W-1:0] b1;
		logic signed [COEF_W-1:0] b2;
		logic signed [COEF_W-1:0] a1;
		logic signed [COEF_W-1:0] a2;
	} coef_t;

endpackage

@@ hdl/iirdf1_datapath.sv @@
module iirdf1_datapath import iirdf1_pkg::*; #(
	parameter int HIST_LEN = 2
) (
	input  logic signed [SAMPLE_W-1:0] x,
	input  logic signed [SAMPLE_W-1:0] x_hist [HIST_LEN],
	input  logic signed [Y_W-1:0]      y_hist [HIST_LEN],
	input  coef_t                      coef,
	output logic signed [Y_W-1:0]      y_full,
	output logic signed [SAMPLE_W-1:0] y_sample
);

	// products are at most 2^40 in magnitude, five of them sum below 2^43
	localparam int BP_W  = COEF_W + SAMPLE_W;
	localparam int AP_W  = COEF_W + Y_W;
	localparam int ACC_W = 45;
	localparam int SH_W  = ACC_W - 14;
	localparam int S_W   = Y_W + 1;
	localparam int SS_W  = S_W - 8;

	localparam logic signed [SH_W-1:0] SH_MAX = SH_W'(2 ** (Y_W - 1) - 1);
	localparam logic signed [SH_W-1:0] SH_MIN = SH_W'(-(2 ** (Y_W - 1)));
	localparam logic signed [SS_W-1:0] SS_MAX = SS_W'(2 ** (SAMPLE_W - 1) - 1);
	localparam logic signed [SS_W-1:0] SS_MIN = SS_W'(-(2 ** (SAMPLE_W - 1)));

	logic signed [BP_W-1:0]  pb0;
	logic signed [BP_W-1:0]  pb [HIST_LEN];
	logic signed [AP_W-1:0]  pa [HIST_LEN];
	logic signed [ACC_W-1:0] acc;
	logic signed [ACC_W-1:0] acc_rnd;
	logic signed [SH_W-1:0]  ysh;
	logic signed [S_W-1:0]   s_rnd;
	logic signed [SS_W-1:0]  ssh;

	// parallel products; only the first two taps have coefficients
	assign pb0 = BP_W'(coef.b0) * BP_W'(x);

	for (genvar k = 0; k < HIST_LEN; k++) begin : g_tap
		if (k == 0) begin : g_t1
			assign pb[k] = BP_W'(coef.b1) * BP_W'(x_hist[k]);
			assign pa[k] = AP_W'(coef.a1) * AP_W'(y_hist[k]);
		end else if (k == 1) begin : g_t2
			assign pb[k] = BP_W'(coef.b2) * BP_W'(x_hist[k]);
			assign pa[k] = AP_W'(coef.a2) * AP_W'(y_hist[k]);
		end else begin : g_tn
			assign pb[k] = '0;
			assign pa[k] = '0;
		end
	end

	// accumulate: feedforward terms carry 8 extra fraction bits
	always_comb begin
		acc = ACC_W'($signed({pb0, 8'd0}));
		for (int k = 0; k < HIST_LEN; k++) begin
			acc = acc + ACC_W'($signed({pb[k], 8'd0})) - ACC_W'(pa[k]);
		end
	end

	// round half up to Q1.23 and saturate to 24 bits
	assign acc_rnd = acc + ACC_W'(2 ** 13);
	assign ysh     = $signed(acc_rnd[ACC_W-1:14]);

	always_comb begin
		if (ysh > SH_MAX) begin
			y_full = Y_W'(SH_MAX);
		end else if (ysh < SH_MIN) begin
			y_full = Y_W'(SH_MIN);
		end else begin
			y_full = Y_W'(ysh);
		end
	end

	// round half up to Q1.15 and saturate to 16 bits
	assign s_rnd = S_W'(y_full) + S_W'(2 ** 7);
	assign ssh   = $signed(s_rnd[S_W-1:8]);

	always_comb begin
		if (ssh > SS_MAX) begin
			y_sample = SAMPLE_W'(SS_MAX);
		end else if (ssh < SS_MIN) begin
			y_sample = SAMPLE_W'(SS_MIN);
		end else begin
			y_sample = SAMPLE_W'(ssh);
		end
	end

endmodule

@@ hdl/iir_direct_form1_filter.sv @@
// Multichannel direct-form-I IIR filter. Each transaction on the slave stream
// carries one Q1.15 sample in tdata and its channel in tuser; the master stream
// returns one rounded, saturated Q1.15 sample per input with the channel echoed.
// The block takes one sample every clock cycle while the master stream is not
// stalled, any mix of channels. An accepted sample is held in the input register,
// then a single multiply-accumulate pass (five parallel multipliers and one adder
// tree) fills the output register, which presents the result on the master
// stream. The per-channel input and output
// histories sit in flip-flops and are shifted at the same edge the result is
// registered, so a sample of the same channel may follow immediately. Histories
// reset to zero; coefficients are Q4.14 and a1 resets to 1.0. A channel number
// at or above CHANNELS yields a zero sample and leaves all histories alone.
// Coefficients should be written only while the filter is idle.
module iir_direct_form1_filter import iirdf1_pkg::*; #(
	parameter int ORDER    = 3,
	parameter int CHANNELS = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	// input stream
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	input  logic [SAMPLE_W-1:0] s_axis_tdata,   // [15:0] sample_in
	input  logic [CHAN_W-1:0]   s_axis_tuser,   // [1:0] chan
	// output stream
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	output logic [SAMPLE_W-1:0] m_axis_tdata,   // [15:0] sample_out
	output logic [CHAN_W-1:0]   m_axis_tuser,   // [1:0] chan_out
	// coefficient write port
	input  logic                cfg_we,
	input  logic [CFG_A_W-1:0]  cfg_addr,
	input  logic [COEF_W-1:0]   cfg_wdata
);

	localparam int HIST_LEN   = ORDER - 1;
	localparam int CHAN_SLOTS = (CHANNELS < 2 ** CHAN_W) ? CHANNELS : 2 ** CHAN_W;

	coef_t                      coef_q;
	logic                       valid_s1;
	logic [CHAN_W-1:0]          chan_s1;
	logic signed [SAMPLE_W-1:0] sample_s1;
	logic                       out_valid_q;
	logic [CHAN_W-1:0]          out_chan_q;
	logic [SAMPLE_W-1:0]        out_sample_q;
	logic signed [SAMPLE_W-1:0] xh_q [CHAN_SLOTS][HIST_LEN];
	logic signed [Y_W-1:0]      yh_q [CHAN_SLOTS][HIST_LEN];
	logic signed [SAMPLE_W-1:0] x_hist [HIST_LEN];
	logic signed [Y_W-1:0]      y_hist [HIST_LEN];
	logic signed [Y_W-1:0]      y_full;
	logic signed [SAMPLE_W-1:0] y_sample;
	logic                       chan_ok;
	logic                       advance;

	// handshake: stage 1 moves on when the output register is free or drains
	assign advance       = !out_valid_q || m_axis_tready;
	assign s_axis_tready = !valid_s1 || advance;
	assign chan_ok       = (int'(chan_s1) < CHANNELS);

	// coefficient registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q.b0 <= COEF_ZERO;
			coef_q.b1 <= COEF_ZERO;
			coef_q.b2 <= COEF_ZERO;
			coef_q.a1 <= COEF_ONE;
			coef_q.a2 <= COEF_ZERO;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_addr))
				REG_B0:  coef_q.b0 <= cfg_wdata;
				REG_B1:  coef_q.b1 <= cfg_wdata;
				REG_B2:  coef_q.b2 <= cfg_wdata;
				REG_A1:  coef_q.a1 <= cfg_wdata;
				REG_A2:  coef_q.a2 <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			chan_s1   <= s_axis_tuser;
			sample_s1 <= $signed(s_axis_tdata);
		end
	end

	// history read for the channel in stage 1
	always_comb begin
		for (int k = 0; k < HIST_LEN; k++) begin
			x_hist[k] = '0;
			y_hist[k] = '0;
		end
		for (int c = 0; c < CHAN_SLOTS; c++) begin
			if (chan_s1 == CHAN_W'(c)) begin
				for (int k = 0; k < HIST_LEN; k++) begin
					x_hist[k] = xh_q[c][k];
					y_hist[k] = yh_q[c][k];
				end
			end
		end
	end

	iirdf1_datapath #(
		.HIST_LEN (HIST_LEN)
	) u_datapath (
		.x        (sample_s1),
		.x_hist   (x_hist),
		.y_hist   (y_hist),
		.coef     (coef_q),
		.y_full   (y_full),
		.y_sample (y_sample)
	);

	// history shift for the channel whose result is registered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < CHAN_SLOTS; c++) begin
				for (int k = 0; k < HIST_LEN; k++) begin
					xh_q[c][k] <= '0;
					yh_q[c][k] <= '0;
				end
			end
		end else if (valid_s1 && advance && chan_ok) begin
			for (int c = 0; c < CHAN_SLOTS; c++) begin
				if (chan_s1 == CHAN_W'(c)) begin
					xh_q[c][0] <= sample_s1;
					yh_q[c][0] <= y_full;
					for (int k = 1; k < HIST_LEN; k++) begin
						xh_q[c][k] <= xh_q[c][k-1];
						yh_q[c][k] <= yh_q[c][k-1];
					end
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			out_chan_q   <= chan_s1;
			out_sample_q <= chan_ok ? y_sample : '0;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_sample_q;
	assign m_axis_tuser  = out_chan_q;

	// a sample leaving stage 1 shows up on the output next cycle
	a_stage_to_out : assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && advance) |=> m_axis_tvalid)
		else $error("stage 1 result lost");

	// no new transaction while both registers are full and the output stalls
	a_no_overrun : assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
		else $error("input accepted with full pipeline");

	// unsupported channels always return silence
	a_bad_chan_zero : assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && (int'(m_axis_tuser) >= CHANNELS)) |-> (m_axis_tdata == '0))
		else $error("nonzero sample for unsupported channel");

endmodule

@@ tb/iir_direct_form1_filter_tb.sv @@
module iir_direct_form1_filter_tb;
	import iirdf1_pkg::*;

	localparam int ORDER       = 3;
	localparam int CHANNELS    = 4;
	localparam int HIST        = ORDER - 1;
	localparam int PHASES      = 16;
	localparam int PHASE_ITEMS = 100;
	localparam int RX_HOLD     = 300;
	localparam int CYCLE_LIMIT = 500000;
	localparam int MAX_SHOWN   = 10;

	// coefficient and sample extremes
	localparam int CMAX = 131071;
	localparam int CMIN = -131072;
	localparam int ONE  = 16384;
	localparam int SMAX = 32767;
	localparam int SMIN = -32768;

	typedef struct packed {
		logic [CHAN_W-1:0]          chan;
		logic signed [SAMPLE_W-1:0] sample;
	} filt_out_t;

	typedef enum logic {ROW_COEF, ROW_SAMPLE} row_kind_t;

	typedef struct {
		row_kind_t                  kind;
		coef_t                      coefs;
		logic [CHAN_W-1:0]          chan;
		logic signed [SAMPLE_W-1:0] sample;
		logic                       chk;
		logic signed [SAMPLE_W-1:0] want;
	} row_t;

	localparam int N_DIR = 27;

	// directed sequence: coefficient loads and samples, fixed results where obvious
	row_t dir_rows [N_DIR] = '{
		// reset coefficients: all-zero history gives zero output
		'{ROW_SAMPLE, '0, 0, SMAX, 1, 0},
		'{ROW_SAMPLE, '0, 1, SMIN, 1, 0},
		'{ROW_SAMPLE, '0, 2, 0, 1, 0},
		'{ROW_SAMPLE, '0, 3, 1, 1, 0},
		'{ROW_SAMPLE, '0, 0, -1, 1, 0},
		// unity pass-through
		'{ROW_COEF, '{ONE, 0, 0, 0, 0}, 0, 0, 0, 0},
		'{ROW_SAMPLE, '0, 0, SMAX, 1, SMAX},
		'{ROW_SAMPLE, '0, 1, SMIN, 1, SMIN},
		'{ROW_SAMPLE, '0, 2, 21845, 1, 21845},
		'{ROW_SAMPLE, '0, 3, -21846, 1, -21846},
		// largest gain saturates both ways
		'{ROW_COEF, '{CMAX, 0, 0, 0, 0}, 0, 0, 0, 0},
		'{ROW_SAMPLE, '0, 0, SMAX, 1, SMAX},
		'{ROW_SAMPLE, '0, 1, SMIN, 1, SMIN},
		'{ROW_SAMPLE, '0, 2, 1, 0, 0},
		// most negative gain flips the rails
		'{ROW_COEF, '{CMIN, 0, 0, 0, 0}, 0, 0, 0, 0},
		'{ROW_SAMPLE, '0, 3, SMAX, 1, SMIN},
		'{ROW_SAMPLE, '0, 0, SMIN, 1, SMAX},
		// b1 to a2 at an extreme with unity b0, then every tap at an extreme
		'{ROW_COEF, '{ONE, CMAX, CMIN, CMAX, CMIN}, 0, 0, 0, 0},
		'{ROW_SAMPLE, '0, 0, SMAX, 0, 0},
		'{ROW_SAMPLE, '0, 0, SMIN, 0, 0},
		'{ROW_SAMPLE, '0, 0, SMAX, 0, 0},
		'{ROW_SAMPLE, '0, 1, 0, 0, 0},
		'{ROW_SAMPLE, '0, 0, 12345, 0, 0},
		'{ROW_COEF, '{CMIN, CMIN, CMAX, CMIN, CMAX}, 0, 0, 0, 0},
		'{ROW_SAMPLE, '0, 2, SMAX, 0, 0},
		'{ROW_SAMPLE, '0, 2, -1, 0, 0},
		'{ROW_SAMPLE, '0, 2, SMIN, 0, 0}
	};

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_axis_tvalid = 1'b0;
	logic                s_axis_tready;
	logic [SAMPLE_W-1:0] s_axis_tdata = '0;   // [15:0] sample_in
	logic [CHAN_W-1:0]   s_axis_tuser = '0;   // [1:0] chan
	logic                m_axis_tvalid;
	logic                m_axis_tready = 1'b0;
	logic [SAMPLE_W-1:0] m_axis_tdata;        // [15:0] sample_out
	logic [CHAN_W-1:0]   m_axis_tuser;        // [1:0] chan_out
	logic                cfg_we = 1'b0;
	logic [CFG_A_W-1:0]  cfg_addr = '0;
	logic [COEF_W-1:0]   cfg_wdata = '0;

	// fixed result carried along with a directed sample
	logic                       table_chk = 1'b0;
	logic signed [SAMPLE_W-1:0] table_want = '0;

	// filter state mirrored from the port activity
	logic signed [COEF_W-1:0]   coef_reg [5] = '{COEF_ZERO, COEF_ZERO, COEF_ZERO, COEF_ONE, COEF_ZERO};
	logic signed [SAMPLE_W-1:0] x_hist [CHANNELS][HIST] = '{default: '0};
	logic signed [Y_W-1:0]      y_hist [CHANNELS][HIST] = '{default: '0};

	filt_out_t awaited_samples [$];
	int        mismatches = 0;
	int        burst_left = 0;
	bit        rx_hold_req = 1'b0;

	iir_direct_form1_filter #(
		.ORDER    (ORDER),
		.CHANNELS (CHANNELS)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata)
	);

	always #4 clk = ~clk;

	// one filter step: accumulate, round to q1.23, round to q1.15, shift histories
	function automatic logic signed [SAMPLE_W-1:0] filter_sample(logic [CHAN_W-1:0] ch,
			logic signed [SAMPLE_W-1:0] x);
		longint acc, y, s;
		logic signed [COEF_W-1:0] b, a;
		if (ch >= CHANNELS)
			return '0;
		acc = longint'(coef_reg[REG_B0]) * longint'(x) * 256;
		for (int k = 1; k <= HIST; k++) begin
			b = (k == 1) ? coef_reg[REG_B1] : (k == 2) ? coef_reg[REG_B2] : COEF_ZERO;
			a = (k == 1) ? coef_reg[REG_A1] : (k == 2) ? coef_reg[REG_A2] : COEF_ZERO;
			acc += longint'(b) * longint'(x_hist[ch][k-1]) * 256;
			acc -= longint'(a) * longint'(y_hist[ch][k-1]);
		end
		y = (acc + 8192) >>> 14;
		if (y > 8388607)
			y = 8388607;
		else if (y < -8388608)
			y = -8388608;
		s = (y + 128) >>> 8;
		if (s > SMAX)
			s = SMAX;
		else if (s < SMIN)
			s = SMIN;
		for (int k = HIST - 1; k > 0; k--) begin
			x_hist[ch][k] = x_hist[ch][k-1];
			y_hist[ch][k] = y_hist[ch][k-1];
		end
		x_hist[ch][0] = x;
		y_hist[ch][0] = Y_W'(y);
		return SAMPLE_W'(s);
	endfunction

	function automatic logic signed [COEF_W-1:0] rand_coef(int lim);
		int v;
		v = int'($urandom_range(0, 2 * lim - 1)) - lim;
		return COEF_W'(v);
	endfunction

	function automatic logic signed [COEF_W-1:0] rail_coef();
		return ($urandom_range(0, 1) != 0) ? COEF_W'(CMAX) : COEF_W'(CMIN);
	endfunction

	// offer one sample; bursts with random gaps in between
	task automatic send_sample(logic [CHAN_W-1:0] ch, logic signed [SAMPLE_W-1:0] smp,
			logic chk, logic signed [SAMPLE_W-1:0] want);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 12));
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = int'($urandom_range(1, 48));
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= smp;
		s_axis_tuser  <= ch;
		table_chk     <= chk;
		table_want    <= want;
		do @(posedge clk); while (!s_axis_tready);
		burst_left--;
	endtask

	// stop offering and let every outstanding sample come back
	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (awaited_samples.size() != 0)
			@(posedge clk);
	endtask

	// write all five coefficients while the filter is idle
	task automatic load_coefs(coef_t c);
		reg_idx_t r;
		wait_idle();
		repeat (2) @(posedge clk);
		r = REG_B0;
		do begin
			cfg_we   <= 1'b1;
			cfg_addr <= r;
			case (r)
				REG_B0: cfg_wdata <= c.b0;
				REG_B1: cfg_wdata <= c.b1;
				REG_B2: cfg_wdata <= c.b2;
				REG_A1: cfg_wdata <= c.a1;
				default: cfg_wdata <= c.a2;
			endcase
			@(posedge clk);
			r = r.next();
		end while (r != REG_B0);
		cfg_we <= 1'b0;
	endtask

	// track coefficient writes, predict accepted samples, check returned samples
	always @(posedge clk) begin
		filt_out_t got, want;
		if (cfg_we && cfg_addr <= REG_A2)
			coef_reg[cfg_addr] = cfg_wdata;
		if (s_axis_tvalid && s_axis_tready) begin
			want.chan   = s_axis_tuser;
			want.sample = filter_sample(s_axis_tuser, s_axis_tdata);
			if (table_chk)
				want.sample = table_want;
			awaited_samples.push_back(want);
		end
		if (m_axis_tvalid && m_axis_tready) begin
			got.chan   = m_axis_tuser;
			got.sample = m_axis_tdata;
			if (awaited_samples.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_SHOWN)
					$display("unexpected transaction: chan %0d sample %0d",
						got.chan, $signed(got.sample));
			end else begin
				want = awaited_samples.pop_front();
				if (got.chan !== want.chan || got.sample !== want.sample) begin
					mismatches++;
					if (mismatches <= MAX_SHOWN)
						$display("mismatch: chan %0d sample %0d, expected chan %0d sample %0d",
							got.chan, $signed(got.sample), want.chan, $signed(want.sample));
				end
			end
		end
	end

	// receiver: windows of different stall rates, plus one long hold-off on request
	initial begin
		int win, pct;
		forever begin
			win = int'($urandom_range(10, 80));
			case ($urandom_range(0, 3))
				0: pct = 0;
				1: pct = 20;
				2: pct = 50;
				default: pct = 85;
			endcase
			repeat (win) begin
				@(posedge clk);
				if (rx_hold_req) begin
					rx_hold_req = 1'b0;
					m_axis_tready <= 1'b0;
					repeat (RX_HOLD) @(posedge clk);
				end
				m_axis_tready <= (int'($urandom_range(0, 99)) >= pct);
			end
		end
	end

	// watchdog
	initial begin
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("*** FAILED ***");
		$finish;
	end

	// stimulus
	initial begin
		logic [CHAN_W-1:0]          ch;
		logic signed [SAMPLE_W-1:0] smp;
		coef_t                      c;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows
		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_COEF)
				load_coefs(dir_rows[i].coefs);
			else
				send_sample(dir_rows[i].chan, dir_rows[i].sample, dir_rows[i].chk,
					dir_rows[i].want);
		end

		// random phases, each with its own coefficient set
		for (int p = 0; p < PHASES; p++) begin
			case (p % 4)
				0: begin
					// mild, stable filter
					c.b0 = rand_coef(16384);
					c.b1 = rand_coef(16384);
					c.b2 = rand_coef(16384);
					c.a1 = rand_coef(8192);
					c.a2 = rand_coef(4096);
				end
				1: begin
					c.b0 = rand_coef(131072);
					c.b1 = rand_coef(131072);
					c.b2 = rand_coef(131072);
					c.a1 = rand_coef(131072);
					c.a2 = rand_coef(131072);
				end
				2: begin
					// rails only
					c.b0 = rail_coef();
					c.b1 = rail_coef();
					c.b2 = rail_coef();
					c.a1 = rail_coef();
					c.a2 = rail_coef();
				end
				default: begin
					c.b0 = rand_coef(32768);
					c.b1 = rand_coef(32768);
					c.b2 = rand_coef(32768);
					c.a1 = rand_coef(32768);
					c.a2 = rand_coef(16384);
				end
			endcase
			load_coefs(c);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (p == 5 && i == 40)
					rx_hold_req = 1'b1;
				if (p == 9 && i == 50)
					wait_idle();
				ch = CHAN_W'($urandom_range(0, (1 << CHAN_W) - 1));
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4: smp = SAMPLE_W'($urandom);
					5, 6: smp = SAMPLE_W'(int'($urandom_range(0, 511)) - 256);
					7: smp = SAMPLE_W'(SMAX);
					8: smp = SAMPLE_W'(SMIN);
					default: smp = SAMPLE_W'(int'($urandom_range(0, 2)) - 1);
				endcase
				send_sample(ch, smp, 1'b0, '0);
			end
		end

		wait_idle();
		repeat (10) @(posedge clk);
		if (mismatches == 0 && awaited_samples.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
